[src/mstk_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mstk_pkg
// Types and constants shared by the minimum spanning tree block.
// ----------------------------------------------------------------------------
package mstk_pkg;

	localparam int MaxNodes = 32;
	localparam int MaxEdges = 64;
	localparam int NodeW    = $clog2(MaxNodes);
	localparam int EdgeW    = $clog2(MaxEdges);
	localparam int CntW     = EdgeW + 1;
	localparam int KeyW     = 36;
	localparam int RankW    = 3;

	localparam logic [1:0] LinkWired    = 2'd0;
	localparam logic [1:0] LinkWireless = 2'd1;

	typedef enum logic [3:0] {
		S_LOAD,
		S_INIT,
		S_NEXT,
		S_SCAN,
		S_SLAST,
		S_PICK,
		S_FCHK,
		S_FGP,
		S_JOIN,
		S_JOIN2,
		S_ERD,
		S_EWR
	} mst_state_t;

	typedef struct packed {
		logic [KeyW-1:0]  key;
		logic [NodeW-1:0] dst;
		logic [NodeW-1:0] src;
	} edge_entry_t;

	typedef struct packed {
		logic [RankW-1:0] rank;
		logic [NodeW-1:0] parent;
	} uf_entry_t;

endpackage

[src/minimum_spanning_tree_kruskal.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minimum_spanning_tree_kruskal
// Kruskal spanning tree over up to 64 weighted edges with union-find.
// ----------------------------------------------------------------------------
// Edges arrive on the s_ stream, one beat per cycle while the block is
// loading; s_tlast marks the final edge of a set and starts the run. Edges
// with a bad endpoint or beyond 64 stored are dropped and flagged.
// The run initialises the 32-entry union-find RAM, then for each tree
// position scans the edge RAM for the next key in (key, index) order and
// walks both roots through the union-find RAM before joining. It stops at
// min(node_count, 32)-1 tree edges or when all edges are used.
// Results leave on the m_ stream in load order, one per stored edge, at most
// one beat in flight (flag RAM read then output register); m_tlast
// marks the final one. While m_tready is low the output register holds and
// the block waits. s_tready is high only while loading. A set with no stored
// edge yields no result. Reset returns to loading with an empty store and
// node_count 32; no memory clearing pass is needed.
// ----------------------------------------------------------------------------
module minimum_spanning_tree_kruskal
	import mstk_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // src_node, dst_node, weight, zero fill
	input  logic [1:0]  s_tuser,  // link_type
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // edge_index, in_tree, tree_edges, dropped, zero fill
	output logic        m_tlast
);

	mst_state_t state_q, state_d;

	logic [5:0]       node_count_q;
	logic [CntW-1:0]  cnt_q, cnt_next;
	logic             drop_q, drop_next;
	logic [NodeW-1:0] limit_q, chosen_q;
	logic [CntW-1:0]  pos_q;
	logic [EdgeW-1:0] j_q, j_s1, k_q;
	logic             scan_v_s1;
	logic             best_v_q, prev_v_q;
	edge_entry_t      best_q;
	logic [EdgeW-1:0] best_idx_q;
	logic [KeyW+EdgeW-1:0] prev_q, cand, best_key;
	logic [NodeW-1:0] x_q, ra_q, rb_q;
	logic [RankW-1:0] rkx_q, rka_q, rkb_q;
	logic             side_q;
	logic             out_valid_q, out_tree_q, out_last_q, out_drop_q;
	logic [EdgeW-1:0] out_idx_q;
	logic [NodeW-1:0] out_cnt_q;

	edge_entry_t      edge_mem [MaxEdges];
	logic             flag_mem [MaxEdges];
	uf_entry_t        uf_mem   [MaxNodes];

	logic             edge_we, flag_we, flag_wd, uf_we;
	logic [EdgeW-1:0] edge_wa, edge_ra, flag_wa, flag_ra;
	edge_entry_t      edge_wd, edge_rd_q;
	logic             flag_rd_q;
	logic [NodeW-1:0] uf_wa, uf_ra;
	uf_entry_t        uf_wd, uf_rd_q;

	logic [NodeW-1:0] in_src, in_dst;
	logic [31:0]      in_w;
	logic [KeyW-1:0]  in_key;
	logic [5:0]       nodes_eff;
	logic             in_acc, keep, cfg_wr;

	assign in_src = s_tdata[NodeW-1:0];
	assign in_dst = s_tdata[2*NodeW-1:NodeW];
	assign in_w   = s_tdata[2*NodeW+31:2*NodeW];

	always_comb begin
		case (s_tuser)
			LinkWired:    in_key = {4'd0, in_w};
			LinkWireless: in_key = {2'd0, in_w, 2'd0} + {4'd0, in_w};
			default:      in_key = {1'b0, in_w, 3'd0} + {3'd0, in_w, 1'b0};
		endcase
	end

	assign nodes_eff = (node_count_q > 6'(MaxNodes)) ? 6'(MaxNodes) : node_count_q;
	assign s_tready  = (state_q == S_LOAD);
	assign in_acc    = s_tvalid && s_tready;
	assign keep      = ({1'b0, in_src} < nodes_eff) && ({1'b0, in_dst} < nodes_eff)
		&& !cnt_q[CntW-1];
	assign cnt_next  = (in_acc && keep) ? cnt_q + CntW'(1) : cnt_q;
	assign drop_next = drop_q || (in_acc && !keep);

	assign cand     = {edge_rd_q.key, j_s1};
	assign best_key = {best_q.key, best_idx_q};

	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {26'd0, node_count_q};

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {3'd0, out_drop_q, out_cnt_q, out_tree_q, out_idx_q};

	// memories
	always_ff @(posedge clk) begin
		if (edge_we)
			edge_mem[edge_wa] <= edge_wd;
		edge_rd_q <= edge_mem[edge_ra];
	end

	always_ff @(posedge clk) begin
		if (flag_we)
			flag_mem[flag_wa] <= flag_wd;
		flag_rd_q <= flag_mem[flag_ra];
	end

	always_ff @(posedge clk) begin
		if (uf_we)
			uf_mem[uf_wa] <= uf_wd;
		uf_rd_q <= uf_mem[uf_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_LOAD;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		edge_we = 1'b0;
		edge_wa = cnt_q[EdgeW-1:0];
		edge_wd = '{key: in_key, dst: in_dst, src: in_src};
		edge_ra = j_q;
		flag_we = 1'b0;
		flag_wa = cnt_q[EdgeW-1:0];
		flag_wd = 1'b0;
		flag_ra = k_q;
		uf_we   = 1'b0;
		uf_wa   = x_q;
		uf_wd   = '{rank: '0, parent: j_q[NodeW-1:0]};
		uf_ra   = x_q;
		unique case (state_q)
			S_LOAD: begin
				edge_we = in_acc && keep;
				flag_we = in_acc && keep;
				if (in_acc && s_tlast && (cnt_next != '0))
					state_d = S_INIT;
			end
			S_INIT: begin
				uf_we = 1'b1;
				uf_wa = j_q[NodeW-1:0];
				if (j_q[NodeW-1:0] == NodeW'(MaxNodes - 1))
					state_d = S_NEXT;
			end
			S_NEXT: begin
				if ((pos_q == cnt_q) || (chosen_q >= limit_q))
					state_d = S_ERD;
				else
					state_d = S_SCAN;
			end
			S_SCAN: begin
				if ({1'b0, j_q} == cnt_q - CntW'(1))
					state_d = S_SLAST;
			end
			S_SLAST: state_d = S_PICK;
			S_PICK: begin
				uf_ra   = best_q.src;
				state_d = S_FCHK;
			end
			S_FCHK: begin
				if (uf_rd_q.parent == x_q) begin
					if (!side_q)
						uf_ra = best_q.dst;
					else
						state_d = S_JOIN;
				end else begin
					uf_ra   = uf_rd_q.parent;
					state_d = S_FGP;
				end
			end
			S_FGP: begin
				// path halving: point x at its grandparent
				uf_we   = 1'b1;
				uf_wa   = x_q;
				uf_wd   = '{rank: rkx_q, parent: uf_rd_q.parent};
				uf_ra   = uf_rd_q.parent;
				state_d = S_FCHK;
			end
			S_JOIN: begin
				state_d = S_NEXT;
				if (ra_q != rb_q) begin
					flag_we = 1'b1;
					flag_wa = best_idx_q;
					flag_wd = 1'b1;
					uf_we   = 1'b1;
					if (rka_q < rkb_q) begin
						uf_wa = ra_q;
						uf_wd = '{rank: rka_q, parent: rb_q};
					end else begin
						uf_wa = rb_q;
						uf_wd = '{rank: rkb_q, parent: ra_q};
						if (rka_q == rkb_q)
							state_d = S_JOIN2;
					end
				end
			end
			S_JOIN2: begin
				uf_we   = 1'b1;
				uf_wa   = ra_q;
				uf_wd   = '{rank: rka_q + RankW'(1), parent: ra_q};
				state_d = S_NEXT;
			end
			S_ERD: begin
				if (!out_valid_q || m_tready)
					state_d = S_EWR;
			end
			S_EWR: begin
				if ({1'b0, k_q} == cnt_q - CntW'(1))
					state_d = S_LOAD;
				else
					state_d = S_ERD;
			end
			default: state_d = S_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= 6'(MaxNodes);
			cnt_q        <= '0;
			drop_q       <= 1'b0;
			limit_q      <= '0;
			chosen_q     <= '0;
			pos_q        <= '0;
			j_q          <= '0;
			k_q          <= '0;
			scan_v_s1    <= 1'b0;
			best_v_q     <= 1'b0;
			prev_v_q     <= 1'b0;
			side_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr && !paddr[2])
				node_count_q <= pwdata[5:0];
			scan_v_s1 <= (state_q == S_SCAN);
			if (scan_v_s1 && (!prev_v_q || cand > prev_q) && (!best_v_q || cand < best_key))
				best_v_q <= 1'b1;
			if (state_q == S_EWR)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_LOAD: begin
					cnt_q  <= cnt_next;
					drop_q <= (in_acc && s_tlast && (cnt_next == '0)) ? 1'b0 : drop_next;
					j_q    <= '0;
				end
				S_INIT: begin
					j_q      <= j_q + EdgeW'(1);
					chosen_q <= '0;
					pos_q    <= '0;
					k_q      <= '0;
					prev_v_q <= 1'b0;
					limit_q  <= (nodes_eff == '0) ? '0 : NodeW'(nodes_eff - 6'd1);
				end
				S_NEXT: begin
					j_q      <= '0;
					best_v_q <= 1'b0;
				end
				S_SCAN: j_q <= j_q + EdgeW'(1);
				S_PICK: begin
					x_q      <= best_q.src;
					side_q   <= 1'b0;
					prev_q   <= best_key;
					prev_v_q <= 1'b1;
				end
				S_FCHK: begin
					if (uf_rd_q.parent == x_q) begin
						if (!side_q) begin
							ra_q   <= x_q;
							rka_q  <= uf_rd_q.rank;
							side_q <= 1'b1;
							x_q    <= best_q.dst;
						end else begin
							rb_q  <= x_q;
							rkb_q <= uf_rd_q.rank;
						end
					end else begin
						rkx_q <= uf_rd_q.rank;
					end
				end
				S_FGP: x_q <= uf_rd_q.parent;
				S_JOIN: begin
					pos_q <= pos_q + CntW'(1);
					if (ra_q != rb_q)
						chosen_q <= chosen_q + NodeW'(1);
				end
				S_EWR: begin
					if ({1'b0, k_q} == cnt_q - CntW'(1)) begin
						k_q    <= '0;
						cnt_q  <= '0;
						drop_q <= 1'b0;
					end else begin
						k_q <= k_q + EdgeW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (scan_v_s1 && (!prev_v_q || cand > prev_q) && (!best_v_q || cand < best_key)) begin
			best_q     <= edge_rd_q;
			best_idx_q <= j_s1;
		end
		j_s1 <= j_q;
		if (state_q == S_EWR) begin
			out_idx_q  <= k_q;
			out_tree_q <= flag_rd_q;
			out_cnt_q  <= chosen_q;
			out_drop_q <= drop_q;
			out_last_q <= ({1'b0, k_q} == cnt_q - CntW'(1));
		end
	end

	a_join_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_JOIN) |-> (chosen_q < limit_q))
		else $error("join entered with tree already complete");

	a_emit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EWR) |-> !out_valid_q)
		else $error("result overwrites pending beat");

	a_halving_nonroot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FGP) |-> (uf_rd_q.parent != x_q))
		else $error("path halving loops back to start node");

endmodule
